[rtl/core/vre_pkg.sv]
// Package for the vertex rotation engine: CORDIC constants, opcodes and
// fixed-point helper types. No dependencies.
package vre_pkg;

  typedef enum logic [1:0] {
    OP_ROT_X   = 2'd0,
    OP_ROT_Y   = 2'd1,
    OP_ROT_Z   = 2'd2,
    OP_ROT_AXIS = 2'd3
  } opcode_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z = 2'd2;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [33:0] cordic_t;

  function automatic logic signed [33:0] atan_turn(input int unsigned idx);
    logic signed [33:0] val;
    case (idx)
      0: val = 34'sd536870912;
      1: val = 34'sd316933406;
      2: val = 34'sd167458907;
      3: val = 34'sd85004756;
      4: val = 34'sd42667331;
      5: val = 34'sd21354465;
      6: val = 34'sd10679838;
      7: val = 34'sd5340245;
      8: val = 34'sd2670163;
      9: val = 34'sd1335087;
      10: val = 34'sd667544;
      11: val = 34'sd333772;
      12: val = 34'sd166886;
      13: val = 34'sd83443;
      14: val = 34'sd41722;
      15: val = 34'sd20861;
      16: val = 34'sd10430;
      17: val = 34'sd5215;
      18: val = 34'sd2608;
      19: val = 34'sd1304;
      20: val = 34'sd652;
      21: val = 34'sd326;
      22: val = 34'sd163;
      23: val = 34'sd81;
      default: val = 34'sd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/core/vre_stream_if.sv]
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
interface vre_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/vre_cordic_cell.sv]
// One rotation-mode CORDIC cell with its pipeline register and sideband.
// Depends on vre_pkg.
module vre_cordic_cell #(
  parameter int unsigned STAGE = 0,
  parameter type side_t = logic
) (
  input  logic                     clk,
  input  logic                     en,
  input  vre_pkg::cordic_t         x_in,
  input  vre_pkg::cordic_t         y_in,
  input  vre_pkg::cordic_t         z_in,
  input  side_t                    side_in,
  output vre_pkg::cordic_t         x_out,
  output vre_pkg::cordic_t         y_out,
  output vre_pkg::cordic_t         z_out,
  output side_t                    side_out
);
  vre_pkg::cordic_t x_r, y_r, z_r;
  side_t side_r;
  vre_pkg::cordic_t dx, dy, at;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;
  assign at = vre_pkg::atan_turn(STAGE);

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      if (!z_in[33]) begin
        x_r <= x_in - dx;
        y_r <= y_in + dy;
        z_r <= z_in - at;
      end else begin
        x_r <= x_in + dx;
        y_r <= y_in - dy;
        z_r <= z_in + at;
      end
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign side_out = side_r;
endmodule

[rtl/core/vre_transform.sv]
// Matrix build and vertex multiply pipeline after the CORDIC chain.
// Depends on vre_pkg.
module vre_transform #(
  parameter int unsigned CW = 24,
  parameter type side_t = logic
) (
  input  logic             clk,
  input  logic             en,
  input  vre_pkg::cordic_t cx,
  input  vre_pkg::cordic_t cy,
  input  side_t            side_in,
  input  vre_pkg::q14_t    ax,
  input  vre_pkg::q14_t    ay,
  input  vre_pkg::q14_t    az,
  output logic signed [CW-1:0] rx,
  output logic signed [CW-1:0] ry,
  output logic signed [CW-1:0] rz,
  output logic                 ovf
);
  localparam int unsigned PW = CW + 20;

  // Stage A: round, flip-correct and clamp cosine/sine.
  logic signed [33:0] xr, yr;
  logic signed [18:0] cr, sr, c_fix, s_fix;
  vre_pkg::q14_t c_a_r, s_a_r;
  side_t side_a_r;
  always_comb begin
    xr = (cx + 34'sd32768) >>> 16;
    yr = (cy + 34'sd32768) >>> 16;
    cr = side_in.flip ? -xr[18:0] : xr[18:0];
    sr = side_in.flip ? -yr[18:0] : yr[18:0];
    c_fix = (cr > 19'sd16384) ? 19'sd16384 : ((cr < -19'sd16384) ? -19'sd16384 : cr);
    s_fix = (sr > 19'sd16384) ? 19'sd16384 : ((sr < -19'sd16384) ? -19'sd16384 : sr);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_a_r <= c_fix[15:0];
      s_a_r <= s_fix[15:0];
      side_a_r <= side_in;
    end
  end

  // Stage B: axis products.
  logic signed [31:0] aa_r [3][3];
  logic signed [31:0] as_r [3];
  logic signed [17:0] t_b_r;
  vre_pkg::q14_t c_b_r, s_b_r;
  side_t side_b_r;
  vre_pkg::q14_t av [3];
  assign av[0] = ax;
  assign av[1] = ay;
  assign av[2] = az;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) aa_r[i][j] <= 32'(av[i] * av[j]);
        as_r[i] <= 32'(av[i] * s_a_r);
      end
      t_b_r <= 18'sd16384 - 18'(c_a_r);
      c_b_r <= c_a_r;
      s_b_r <= s_a_r;
      side_b_r <= side_a_r;
    end
  end

  // Stage C: matrix entries.
  logic signed [19:0] m_r [3][3];
  side_t side_c_r;
  logic signed [63:0] me [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        me[i][j] = 64'(aa_r[i][j]) * 64'(t_b_r);
        if (i == j) me[i][j] = me[i][j] + (64'(c_b_r) <<< 28);
      end
    me[0][1] = me[0][1] - (64'(as_r[2]) <<< 14);
    me[0][2] = me[0][2] + (64'(as_r[1]) <<< 14);
    me[1][0] = me[1][0] + (64'(as_r[2]) <<< 14);
    me[1][2] = me[1][2] - (64'(as_r[0]) <<< 14);
    me[2][0] = me[2][0] - (64'(as_r[1]) <<< 14);
    me[2][1] = me[2][1] + (64'(as_r[0]) <<< 14);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_c_r <= side_b_r;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          m_r[i][j] <= (i == j) ? 20'sd16384 : 20'sd0;
          if (side_b_r.op == vre_pkg::OP_ROT_AXIS) begin
            m_r[i][j] <= 20'((me[i][j] + 64'sd134217728) >>> 28);
          end
        end
      case (side_b_r.op)
        vre_pkg::OP_ROT_X: begin
          m_r[1][1] <= 20'(c_b_r); m_r[1][2] <= -20'(s_b_r);
          m_r[2][1] <= 20'(s_b_r); m_r[2][2] <= 20'(c_b_r);
        end
        vre_pkg::OP_ROT_Y: begin
          m_r[0][0] <= 20'(c_b_r); m_r[0][2] <= 20'(s_b_r);
          m_r[2][0] <= -20'(s_b_r); m_r[2][2] <= 20'(c_b_r);
        end
        vre_pkg::OP_ROT_Z: begin
          m_r[0][0] <= 20'(c_b_r); m_r[0][1] <= -20'(s_b_r);
          m_r[1][0] <= 20'(s_b_r); m_r[1][1] <= 20'(c_b_r);
        end
        default: ;
      endcase
    end
  end

  // Stage D: products.
  logic signed [PW-1:0] p_r [3][3];
  logic signed [CW-1:0] vv [3];
  assign vv[0] = side_c_r.vx;
  assign vv[1] = side_c_r.vy;
  assign vv[2] = side_c_r.vz;
  always_ff @(posedge clk) begin
    if (en)
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) p_r[i][j] <= PW'(m_r[i][j]) * PW'(vv[j]);
  end

  // Stage E: sum, round, saturate.
  localparam logic signed [PW+1:0] HI = (PW+2)'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [PW+1:0] LO = -(PW+2)'(64'sd1 <<< (CW-1));
  logic signed [PW+1:0] sum [3];
  logic [2:0] sat;
  logic signed [CW-1:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = ((PW+2)'(p_r[i][0]) + (PW+2)'(p_r[i][1]) + (PW+2)'(p_r[i][2])
                + (PW+2)'(8192)) >>> 14;
      sat[i] = (sum[i] > HI) || (sum[i] < LO);
      res[i] = (sum[i] > HI) ? HI[CW-1:0] : ((sum[i] < LO) ? LO[CW-1:0] : sum[i][CW-1:0]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rx <= res[0];
      ry <= res[1];
      rz <= res[2];
      ovf <= |sat;
    end
  end
endmodule

[rtl/core/vertex_rotation_engine_unit.sv]
// Vertex rotation engine: pipelined CORDIC chain feeding a matrix transform.
// Depends on vre_pkg, vre_stream_if, vre_cordic_cell and vre_transform.
//
// Usage: input items (opcode, vertex, turn angle) arrive on in_ch and one
// rotated vertex with an overflow flag leaves on out_ch for each item.
// The user must write the axis registers (cfg_we/cfg_idx/cfg_data) only while
// idle; the block itself does not enforce this. Each item passes through the
// row of CORDIC cells (CORDIC_STAGES, capped at ATAN_ENTRIES) and then five
// transform stages; one item is accepted per cycle unless out_ch stalls.
// The whole pipeline advances together: when out_ch is stalled while a
// result is valid, every stage holds and in_ch.ready drops, so items are
// never lost. Ready is high whenever the output stage is empty or taken.
// Reset clears all valid bits and loads the axis registers to (0, 0, 1.0).
module vertex_rotation_engine_unit #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  vre_stream_if.sink  in_ch,
  vre_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [vre_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0] cfg_data
);
  localparam int unsigned NST = (CORDIC_STAGES > vre_pkg::ATAN_ENTRIES) ?
                                vre_pkg::ATAN_ENTRIES : CORDIC_STAGES;
  localparam int unsigned DEPTH = NST + 5;

  typedef struct packed {
    vre_pkg::opcode_t op;
    logic flip;
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic signed [COORD_WIDTH-1:0] vz;
  } side_t;

  vre_pkg::q14_t ax_r, ay_r, az_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; az_r <= vre_pkg::Q14_ONE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vre_pkg::CFG_AXIS_X: ax_r <= cfg_data;
        vre_pkg::CFG_AXIS_Y: ay_r <= cfg_data;
        vre_pkg::CFG_AXIS_Z: az_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DEPTH-1:0] vld_r;
  logic en;
  assign en = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
  end

  logic [15:0] ang, red;
  logic flip;
  side_t side0;
  assign ang = in_ch.data.turn_angle;
  assign flip = ang[15] ^ ang[14];
  assign red = flip ? (ang - 16'h8000) : ang;
  always_comb begin
    side0.op = vre_pkg::opcode_t'(in_ch.data.opcode);
    side0.flip = flip;
    side0.vx = in_ch.data.vertex_x;
    side0.vy = in_ch.data.vertex_y;
    side0.vz = in_ch.data.vertex_z;
  end

  vre_pkg::cordic_t xs [NST+1];
  vre_pkg::cordic_t ys [NST+1];
  vre_pkg::cordic_t zs [NST+1];
  side_t ss [NST+1];
  assign xs[0] = vre_pkg::CORDIC_START;
  assign ys[0] = '0;
  assign zs[0] = {{2{red[15]}}, red, 16'h0000};
  assign ss[0] = side0;

  for (genvar g = 0; g < NST; g++) begin : g_cell
    vre_cordic_cell #(.STAGE(g), .side_t(side_t)) u_cell (
      .clk(clk), .en(en),
      .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]), .side_in(ss[g]),
      .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1]), .side_out(ss[g+1])
    );
  end

  vre_transform #(.CW(COORD_WIDTH), .side_t(side_t)) u_xf (
    .clk(clk), .en(en), .cx(xs[NST]), .cy(ys[NST]), .side_in(ss[NST]),
    .ax(ax_r), .ay(ay_r), .az(az_r),
    .rx(out_ch.data.rotated_x), .ry(out_ch.data.rotated_y),
    .rz(out_ch.data.rotated_z), .ovf(out_ch.data.overflow)
  );

  assign out_ch.valid = vld_r[DEPTH-1];

`ifndef SYNTHESIS
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready) else $error("ready low with empty output");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped under stall");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0]) else $error("item not captured");
`endif
endmodule
